[design/a2d_pkg.sv]
// ----------------------------------------------------------------------------
// a2d_pkg: shared types, constants and arithmetic helpers
// Q16.16 formats, op codes and the controller-to-datapath command struct.
// ----------------------------------------------------------------------------
package a2d_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int PROD_WIDTH = 2 * DATA_WIDTH;
    localparam int ACC_WIDTH  = DATA_WIDTH + 3;

    typedef logic signed [DATA_WIDTH-1:0] t_q;
    typedef logic signed [PROD_WIDTH-1:0] t_prod;
    typedef logic signed [ACC_WIDTH-1:0]  t_acc;

    localparam logic [2:0] OP_IDENT  = 3'd0;
    localparam logic [2:0] OP_TRANS  = 3'd1;
    localparam logic [2:0] OP_ROTATE = 3'd2;
    localparam logic [2:0] OP_SCALE  = 3'd3;
    localparam logic [2:0] OP_VERTEX = 3'd4;

    localparam t_q Q_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam t_q Q_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam t_q Q_ONE = t_q'(64'sd1 << FRAC_BITS);

    // Multiplier operand selects.
    typedef enum logic [3:0] {
        SEL_A, SEL_B, SEL_PX, SEL_PY, SEL_OMA, SEL_OMB, SEL_NB,
        SEL_E0, SEL_E1, SEL_E3, SEL_E4, SEL_M
    } t_sel;

    // Accumulator destinations.
    typedef enum logic [3:0] {
        DST_NONE, DST_E2, DST_E5, DST_N0, DST_N1, DST_N2,
        DST_N3, DST_N4, DST_N5, DST_OX, DST_OY
    } t_dst;

    typedef struct packed {
        logic       load;      // capture the input item
        logic       ident;     // matrix back to identity
        logic       setup;     // build E from the op
        logic       mul;       // issue one product
        t_sel       sel_l;
        t_sel       sel_r;
        logic [2:0] m_idx;
        logic       clr;       // start a new sum
        logic       sub;       // subtract the landing product instead of adding
        logic       add_e;     // add E column-two term after products
        logic       add_m;     // add matrix translation term
        t_dst       dst;       // write the finished sum
        logic       commit;    // copy new matrix into composite
    } t_cmd;

    function automatic t_q sat_acc(input t_acc v);
        if (v > t_acc'(Q_MAX)) return Q_MAX;
        if (v < t_acc'(Q_MIN)) return Q_MIN;
        return t_q'(v);
    endfunction

    // Floor shift by FRAC_BITS, then saturate.
    function automatic t_q sat_prod(input t_prod p);
        t_prod s;
        s = p >>> FRAC_BITS;
        if (s > t_prod'(Q_MAX)) return Q_MAX;
        if (s < t_prod'(Q_MIN)) return Q_MIN;
        return t_q'(s);
    endfunction

endpackage

[design/a2d_datapath.sv]
// ----------------------------------------------------------------------------
// a2d_datapath: matrix store, shared multiplier and accumulator
// One registered multiplier feeds a saturating accumulator under command.
// ----------------------------------------------------------------------------
module a2d_datapath (
    input  logic                 i_clk,
    input  a2d_pkg::t_cmd        i_cmd,
    input  logic [2:0]           i_op,
    input  logic signed [31:0]   i_val_a,
    input  logic signed [31:0]   i_val_b,
    input  logic signed [31:0]   i_ref_x,
    input  logic signed [31:0]   i_ref_y,
    input  logic                 i_rst_n,
    output logic signed [31:0]   o_x,
    output logic signed [31:0]   o_y
);
    import a2d_pkg::*;

    t_q r_a, r_b, r_px, r_py;
    t_q r_e [6];
    t_q r_m [6];
    t_q r_n [6];
    t_q r_ox, r_oy;
    t_prod r_p;
    logic  r_pv;
    t_q    r_sum;
    t_q    n_sum;
    t_q    opl, opr;
    t_q    oma, omb, nb;

    assign oma = sat_acc(t_acc'(Q_ONE) - t_acc'(r_a));
    assign omb = sat_acc(t_acc'(Q_ONE) - t_acc'(r_b));
    assign nb  = sat_acc(-t_acc'(r_b));

    function automatic t_q pick(input t_sel s, input logic [2:0] mi);
        case (s)
            SEL_A:   return r_a;
            SEL_B:   return r_b;
            SEL_PX:  return r_px;
            SEL_PY:  return r_py;
            SEL_OMA: return oma;
            SEL_OMB: return omb;
            SEL_NB:  return nb;
            SEL_E0:  return r_e[0];
            SEL_E1:  return r_e[1];
            SEL_E3:  return r_e[3];
            SEL_E4:  return r_e[4];
            SEL_M:   return r_m[mi];
            default: return '0;
        endcase
    endfunction

    assign opl = pick(i_cmd.sel_l, i_cmd.m_idx);
    assign opr = pick(i_cmd.sel_r, i_cmd.m_idx);

    always_comb begin
        t_acc acc;
        acc = i_cmd.clr ? '0 : t_acc'(r_sum);
        if (r_pv) begin
            if (i_cmd.sub) acc = acc - t_acc'(sat_prod(r_p));
            else           acc = acc + t_acc'(sat_prod(r_p));
        end
        // The vertex translation term joins both products under one saturation.
        if (i_cmd.add_m) acc = acc + t_acc'(
            (i_cmd.dst == DST_OX) ? r_m[2] : r_m[5]);
        n_sum = sat_acc(acc);
        if (i_cmd.add_e) n_sum = sat_acc(t_acc'(n_sum) + t_acc'(
            (i_cmd.dst == DST_N2) ? r_e[2] : r_e[5]));
    end

    always_ff @(posedge i_clk) begin
        r_p  <= t_prod'(opl) * t_prod'(opr);
        r_sum <= n_sum;
        if (i_cmd.load) begin
            r_a  <= i_val_a;
            r_b  <= i_val_b;
            r_px <= i_ref_x;
            r_py <= i_ref_y;
        end
        if (i_cmd.setup) begin
            case (i_op)
                OP_TRANS: begin
                    r_e[0] <= Q_ONE; r_e[1] <= '0; r_e[2] <= r_a;
                    r_e[3] <= '0; r_e[4] <= Q_ONE; r_e[5] <= r_b;
                end
                OP_ROTATE: begin
                    r_e[0] <= r_a; r_e[1] <= nb;
                    r_e[3] <= r_b; r_e[4] <= r_a;
                end
                OP_SCALE: begin
                    r_e[0] <= r_a; r_e[1] <= '0;
                    r_e[3] <= '0; r_e[4] <= r_b;
                end
                default: ;
            endcase
        end
        case (i_cmd.dst)
            DST_E2: r_e[2] <= n_sum;
            DST_E5: r_e[5] <= n_sum;
            DST_N0: r_n[0] <= n_sum;
            DST_N1: r_n[1] <= n_sum;
            DST_N2: r_n[2] <= n_sum;
            DST_N3: r_n[3] <= n_sum;
            DST_N4: r_n[4] <= n_sum;
            DST_N5: r_n[5] <= n_sum;
            DST_OX: r_ox <= n_sum;
            DST_OY: r_oy <= n_sum;
            default: ;
        endcase
    end

    // Matrix and the product-valid flag are control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.ident) begin
            r_m[0] <= Q_ONE; r_m[1] <= '0; r_m[2] <= '0;
            r_m[3] <= '0; r_m[4] <= Q_ONE; r_m[5] <= '0;
        end else if (i_cmd.commit) begin
            for (int k = 0; k < 6; k++) r_m[k] <= r_n[k];
        end
        if (!i_rst_n) r_pv <= 1'b0;
        else          r_pv <= i_cmd.mul;
    end

    assign o_x = r_ox;
    assign o_y = r_oy;
endmodule

[design/a2d_ctrl.sv]
// ----------------------------------------------------------------------------
// a2d_ctrl: sequencer for matrix updates and vertex transforms
// Steps through a microcode table, issuing at most one product per cycle.
// ----------------------------------------------------------------------------
module a2d_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [2:0]    i_op,
    input  logic          i_last_vertex,
    output a2d_pkg::t_cmd o_cmd,
    output logic [2:0]    o_op,
    output logic          o_valid,
    input  logic          i_ready,
    output logic          o_last
);
    import a2d_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_RUN  = 4'b0010,
        ST_OUT  = 4'b0100,
        ST_DONE = 4'b1000
    } t_state;

    t_state     r_state, n_state;
    logic [4:0] r_step;
    logic [2:0] r_op;
    logic       r_last, r_ovalid;
    logic [4:0] n_end;

    // Each step issues at most one product; it lands in the sum on the next step.
    function automatic t_cmd ucode(input logic [2:0] op, input logic [4:0] s);
        t_cmd c;
        logic [4:0] u;
        c = '0;
        c.sel_l = SEL_A; c.sel_r = SEL_A; c.dst = DST_NONE;
        // Rotate and scale first compute E2 and E5 (u = 0..4) and then run the
        // shared matrix product sequence from u = 5. Translate enters at u = 4,
        // an empty step that lets its E settle before the first product.
        u = (op == OP_TRANS) ? s + 5'd4 : s;
        if (op == OP_VERTEX) begin
            case (s)
                5'd0: begin c.mul = 1'b1; c.sel_l = SEL_M; c.m_idx = 3'd0; c.sel_r = SEL_A; end
                5'd1: begin c.mul = 1'b1; c.sel_l = SEL_M; c.m_idx = 3'd1; c.sel_r = SEL_B;
                            c.clr = 1'b1; end
                5'd2: begin c.mul = 1'b1; c.sel_l = SEL_M; c.m_idx = 3'd3; c.sel_r = SEL_A;
                            c.add_m = 1'b1; c.dst = DST_OX; end
                5'd3: begin c.mul = 1'b1; c.sel_l = SEL_M; c.m_idx = 3'd4; c.sel_r = SEL_B;
                            c.clr = 1'b1; end
                5'd4: begin c.add_m = 1'b1; c.dst = DST_OY; end
                default: ;
            endcase
            return c;
        end
        case (u)
            5'd0: begin c.mul = 1'b1;
                c.sel_l = (op == OP_ROTATE) ? SEL_PX : SEL_OMA;
                c.sel_r = (op == OP_ROTATE) ? SEL_OMA : SEL_PX; end
            5'd1: begin c.mul = (op == OP_ROTATE); c.sel_l = SEL_PY; c.sel_r = SEL_B;
                c.clr = 1'b1;
                if (op == OP_SCALE) c.dst = DST_E2; end
            5'd2: begin c.mul = 1'b1; c.clr = (op == OP_SCALE);
                c.sel_l = (op == OP_ROTATE) ? SEL_PY : SEL_OMB;
                c.sel_r = (op == OP_ROTATE) ? SEL_OMA : SEL_PY;
                if (op == OP_ROTATE) c.dst = DST_E2; end
            5'd3: begin c.mul = (op == OP_ROTATE); c.sel_l = SEL_PX; c.sel_r = SEL_B;
                c.clr = 1'b1;
                if (op == OP_SCALE) c.dst = DST_E5; end
            // For rotation the pivot x times sine is taken off the sum.
            5'd4: begin if (op == OP_ROTATE) begin c.sub = 1'b1; c.dst = DST_E5; end end
            5'd5, 5'd7, 5'd9, 5'd11, 5'd13, 5'd15: begin
                c.mul = 1'b1; c.sel_l = (u < 5'd11) ? SEL_E0 : SEL_E3;
                c.sel_r = SEL_M;
                c.m_idx = (u < 5'd11) ? 3'((u - 5'd5) >> 1) : 3'((u - 5'd11) >> 1);
            end
            5'd6, 5'd8, 5'd10, 5'd12, 5'd14, 5'd16: begin
                c.mul = 1'b1; c.sel_l = (u < 5'd11) ? SEL_E1 : SEL_E4;
                c.sel_r = SEL_M;
                c.m_idx = (u < 5'd11) ? 3'(5'd3 + ((u - 5'd6) >> 1)) :
                                        3'(5'd3 + ((u - 5'd12) >> 1));
                c.clr = 1'b1;
            end
            default: ;
        endcase
        // Finished sums for the new matrix land on the odd step after the pair.
        case (u)
            5'd7:  c.dst = DST_N0;
            5'd9:  c.dst = DST_N1;
            5'd11: begin c.dst = DST_N2; end
            5'd13: c.dst = DST_N3;
            5'd15: c.dst = DST_N4;
            5'd17: c.dst = DST_N5;
            5'd18: c.commit = 1'b1;
            default: ;
        endcase
        return c;
    endfunction

    // The add of E2/E5 for new entries 2 and 5 follows the second product.
    always_comb begin
        o_cmd = '0;
        o_cmd.sel_l = SEL_A; o_cmd.sel_r = SEL_A; o_cmd.dst = DST_NONE;
        n_state = r_state;
        n_end = (r_op == OP_VERTEX) ? 5'd4 : (r_op == OP_TRANS) ? 5'd14 : 5'd18;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_op == OP_IDENT) o_cmd.ident = 1'b1;
                    else if (i_op == OP_TRANS || i_op == OP_ROTATE || i_op == OP_SCALE ||
                             i_op == OP_VERTEX) n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                o_cmd = ucode(r_op, r_step);
                if (r_step == 5'd0) o_cmd.setup = 1'b1;
                if (o_cmd.dst == DST_N2 || o_cmd.dst == DST_N5) o_cmd.add_e = 1'b1;
                if (r_step == n_end)
                    n_state = (r_op == OP_VERTEX) ? ST_OUT : ST_IDLE;
            end
            ST_OUT: if (i_ready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_step   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= (r_state == ST_RUN) ? r_step + 5'd1 : 5'd0;
            if (r_state == ST_RUN && n_state == ST_OUT) r_ovalid <= 1'b1;
            else if (i_ready) r_ovalid <= 1'b0;
        end
        if (r_state == ST_IDLE && i_valid) begin
            r_op   <= i_op;
            r_last <= i_last_vertex;
        end
    end

    assign o_ready = (r_state == ST_IDLE);
    assign o_valid = r_ovalid;
    assign o_last  = r_last;
    assign o_op    = r_op;
endmodule

[design/affine_2d_transform_engine_top.sv]
// ----------------------------------------------------------------------------
// affine_2d_transform_engine_top: 2D homogeneous affine transform engine
//
//   channel  signals                                        direction
//   input    i_valid/o_ready, i_op, i_val_a, i_val_b,       in
//            i_ref_x, i_ref_y, i_last_vertex
//   output   o_valid/i_ready, o_out_x, o_out_y, o_last      out
//
// One shared 32x32 multiplier, one product per cycle, sets the time.
// Identity needs no run; a vertex waits for the output transfer; translate
// runs shorter than rotate and scale. Reset loads the identity matrix. The
// block holds o_ready low while an item is worked on or its result waits.
// ----------------------------------------------------------------------------
module affine_2d_transform_engine_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [2:0]         i_op,
    input  logic signed [31:0] i_val_a,
    input  logic signed [31:0] i_val_b,
    input  logic signed [31:0] i_ref_x,
    input  logic signed [31:0] i_ref_y,
    input  logic               i_last_vertex,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_out_x,
    output logic signed [31:0] o_out_y,
    output logic               o_last
);
    import a2d_pkg::*;

    t_cmd       cmd;
    logic [2:0] op_q;

    a2d_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_op(i_op), .i_last_vertex(i_last_vertex), .o_cmd(cmd), .o_op(op_q),
        .o_valid(o_valid), .i_ready(i_ready), .o_last(o_last)
    );

    a2d_datapath u_dp (
        .i_clk(i_clk), .i_cmd(cmd), .i_op(op_q), .i_val_a(i_val_a),
        .i_val_b(i_val_b), .i_ref_x(i_ref_x), .i_ref_y(i_ref_y),
        .i_rst_n(i_rst_n), .o_x(o_out_x), .o_y(o_out_y)
    );
endmodule
